### hw/rtl/park_pkg.sv
// shared constants and arctangent table for the park transform rotator
package park_pkg;

  localparam int AngW  = 32;
  localparam int ZW    = 33;
  localparam int Guard = 16;

  localparam logic signed [32:0] InvGain = 33'sd2608131496;

  localparam logic [31:0] AtanTurn [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

### hw/rtl/park_transform_rotator_core.sv
// park transform rotator: alpha/beta currents and angle in, d/q currents out
//
// input stream s_axis: one word per sample with alpha and beta currents
// (signed q1.15) and the rotor angle, where 2^ANGLE_WIDTH is one full turn.
// output stream m_axis: one word per sample with the d and q currents,
// rounded to nearest and saturated to the signed data range.
// the pipeline has one multiply stage for the gain pre-scale, one
// quarter-turn pre-rotation stage, one stage per cordic micro-rotation
// and one rounding stage that is the output register. a new word is
// taken every clock while the output is empty or consumed.
// when m_axis_tready is low with a word waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
// reset clears all valid bits, so the pipeline starts empty.
module park_transform_rotator_core
  import park_pkg::*;
#(
  parameter int DATA_WIDTH    = 16,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // alpha_current, beta_current, rotor_angle
  input  logic [((2*DATA_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // direct_current, quadrature_current
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int IW     = DATA_WIDTH + 18;
  localparam int OutTW  = ((2*DATA_WIDTH+7)/8)*8;

  logic                          en;
  logic signed [DATA_WIDTH-1:0]  alpha, beta, d_cur, q_cur;
  logic        [ANGLE_WIDTH-1:0] angle;
  logic                          vld_a;
  logic        [CORDIC_STAGES:0] vld_s;
  logic signed [IW-1:0]          x_s [CORDIC_STAGES+1];
  logic signed [IW-1:0]          y_s [CORDIC_STAGES+1];
  logic signed [ZW-1:0]          z_s [CORDIC_STAGES+1];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign alpha = $signed(s_axis_tdata[DATA_WIDTH-1:0]);
  assign beta  = $signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
  assign angle = s_axis_tdata[2*DATA_WIDTH+ANGLE_WIDTH-1:2*DATA_WIDTH];

  park_prerot #(
    .DATA_WIDTH (DATA_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .IW         (IW)
  ) u_prerot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .alpha_i  (alpha),
    .beta_i   (beta),
    .angle_i  (angle),
    .valid_a_o(vld_a),
    .valid_o  (vld_s[0]),
    .x_o      (x_s[0]),
    .y_o      (y_s[0]),
    .z_o      (z_s[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    park_cordic_stage #(
      .IW   (IW),
      .STAGE(i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vld_s[i]),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .z_i    (z_s[i]),
      .valid_o(vld_s[i+1]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .z_o    (z_s[i+1])
    );
  end

  park_round #(
    .DATA_WIDTH(DATA_WIDTH),
    .IW        (IW)
  ) u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vld_s[CORDIC_STAGES]),
    .x_i    (x_s[CORDIC_STAGES]),
    .y_i    (y_s[CORDIC_STAGES]),
    .valid_o(m_axis_tvalid),
    .d_o    (d_cur),
    .q_o    (q_cur)
  );

  assign m_axis_tdata = OutTW'({q_cur, d_cur});

  // a waiting word that is not taken blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // the first stage fills only from an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !s_axis_tvalid |=> !vld_a)
    else $error("pipeline invented a word");

  // a stall keeps every valid bit in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_s) && $stable(vld_a) && m_axis_tvalid)
    else $error("pipeline moved during a stall");

endmodule

### hw/rtl/park_prerot.sv
// gain pre-scaling and quarter-turn pre-rotation, two register stages
module park_prerot
  import park_pkg::*;
#(
  parameter int DATA_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16,
  parameter int IW          = 34
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [DATA_WIDTH-1:0]  alpha_i,
  input  logic signed [DATA_WIDTH-1:0]  beta_i,
  input  logic        [ANGLE_WIDTH-1:0] angle_i,
  output logic                          valid_a_o,
  output logic                          valid_o,
  output logic signed [IW-1:0]          x_o,
  output logic signed [IW-1:0]          y_o,
  output logic signed [ZW-1:0]          z_o
);

  localparam int PW = DATA_WIDTH + 33;
  localparam int SW = PW - Guard;

  localparam logic [1:0] QuadZero  = 2'd0;
  localparam logic [1:0] QuadOne   = 2'd1;
  localparam logic [1:0] QuadTwo   = 2'd2;
  localparam logic [1:0] QuadThree = 2'd3;

  logic signed [PW-1:0] prod_x_d, prod_x_q, prod_y_d, prod_y_q;
  logic        [31:0]   theta, phi, rem;
  logic        [1:0]    quad_d, quad_q;
  logic signed [ZW-1:0] z_a_d, z_a_q;
  logic                 valid_a_q, valid_b_q;
  logic signed [IW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_b_q;

  always_comb begin
    prod_x_d = PW'(alpha_i) * PW'(InvGain);
    prod_y_d = PW'(beta_i) * PW'(InvGain);
    theta    = 32'(angle_i) << (AngW - ANGLE_WIDTH);
    phi      = 32'd0 - theta;
    quad_d   = 2'((phi + 32'h2000_0000) >> 30);
    rem      = phi - {quad_d, 30'd0};
    z_a_d    = ZW'($signed(rem));
  end

  always_comb begin
    xs = IW'($signed(prod_x_q[PW-1:Guard]));
    ys = IW'($signed(prod_y_q[PW-1:Guard]));
    case (quad_q)
      QuadOne: begin
        x_d = -ys;
        y_d = xs;
      end
      QuadTwo: begin
        x_d = -xs;
        y_d = -ys;
      end
      QuadThree: begin
        x_d = ys;
        y_d = -xs;
      end
      QuadZero: begin
        x_d = xs;
        y_d = ys;
      end
      default: begin
        x_d = xs;
        y_d = ys;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      quad_q   <= quad_d;
      z_a_q    <= z_a_d;
      x_q      <= x_d;
      y_q      <= y_d;
      z_b_q    <= z_a_q;
    end
  end

  assign valid_a_o = valid_a_q;
  assign valid_o   = valid_b_q;
  assign x_o       = x_q;
  assign y_o       = y_q;
  assign z_o       = z_b_q;

endmodule

### hw/rtl/park_cordic_stage.sv
// one registered cordic micro-rotation
module park_cordic_stage
  import park_pkg::*;
#(
  parameter int IW    = 34,
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [IW-1:0] x_i,
  input  logic signed [IW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 valid_o,
  output logic signed [IW-1:0] x_o,
  output logic signed [IW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] Atan = ZW'(AtanTurn[STAGE]);

  logic signed [IW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic                 valid_q;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Atan;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

### hw/rtl/park_round.sv
// round to nearest, saturate and hold the output word
module park_round
  import park_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int IW         = 34
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [IW-1:0]         x_i,
  input  logic signed [IW-1:0]         y_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] d_o,
  output logic signed [DATA_WIDTH-1:0] q_o
);

  localparam logic signed [IW-1:0] Half = IW'(64'd1 << (Guard - 1));
  localparam logic signed [IW-1:0] Hi   = IW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic signed [IW-1:0] Lo   = -Hi - IW'(1);

  logic signed [IW-1:0]         rx, ry;
  logic signed [DATA_WIDTH-1:0] d_d, q_d, d_q, q_q;
  logic                         valid_q;

  always_comb begin
    rx = (x_i + Half) >>> Guard;
    ry = (y_i + Half) >>> Guard;
    if (rx > Hi) begin
      d_d = DATA_WIDTH'(Hi);
    end else if (rx < Lo) begin
      d_d = DATA_WIDTH'(Lo);
    end else begin
      d_d = DATA_WIDTH'(rx);
    end
    if (ry > Hi) begin
      q_d = DATA_WIDTH'(Hi);
    end else if (ry < Lo) begin
      q_d = DATA_WIDTH'(Lo);
    end else begin
      q_d = DATA_WIDTH'(ry);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
      q_q <= q_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;
  assign q_o     = q_q;

endmodule

### tb/park_transform_rotator_core_tb.sv
// self-checking testbench for the park transform rotator core
`timescale 1ns / 100ps

module park_transform_rotator_core_tb
  import park_pkg::*;
;

  localparam int DataW    = 16;
  localparam int AngleW   = 16;
  localparam int Stages   = 16;
  localparam int InW      = ((2*DataW+AngleW+7)/8)*8;
  localparam int OutW     = ((2*DataW+7)/8)*8;
  localparam int Latency  = Stages + 3;
  localparam int MaxShown = 10;

  localparam logic [15:0] SatHigh = 16'h7FFF;
  localparam logic [15:0] SatLow  = 16'h8000;

  typedef struct packed {
    logic signed [DataW-1:0] q_cur;
    logic signed [DataW-1:0] d_cur;
  } dq_word_t;

  typedef struct packed {
    logic [DataW-1:0]  alpha;
    logic [DataW-1:0]  beta;
    logic [AngleW-1:0] angle;
    bit                fixed_d;
    bit                fixed_q;
    logic [DataW-1:0]  d_cur;
    logic [DataW-1:0]  q_cur;
  } sample_row_t;

  typedef struct packed {
    int count;
    int send_idle;
    int recv_stall;
  } flow_phase_t;

  localparam int NumRows = 24;
  localparam sample_row_t DirectedRows [NumRows] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 16'h4000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 16'hC000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h7FFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 16'h8000, 16'h4000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 16'h2000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 16'hE000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 16'h2000, 1'b1, 1'b0, SatHigh,  16'h0000},
    '{16'h8000, 16'h8000, 16'h2000, 1'b1, 1'b0, SatLow,   16'h0000},
    '{16'h7FFF, 16'h8000, 16'hE000, 1'b1, 1'b0, SatHigh,  16'h0000},
    '{16'h8000, 16'h7FFF, 16'h6000, 1'b1, 1'b0, SatHigh,  16'h0000},
    '{16'h8000, 16'h8000, 16'hA000, 1'b1, 1'b0, SatHigh,  16'h0000},
    '{16'h7FFF, 16'h8000, 16'h2000, 1'b0, 1'b1, 16'h0000, SatLow},
    '{16'h0001, 16'hFFFF, 16'h1234, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'h0001, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000}
  };

  localparam int NumPhases = 5;
  localparam flow_phase_t FlowPhases [NumPhases] = '{
    '{400, 0,  0},
    '{350, 87, 0},
    '{350, 0,  87},
    '{400, 27, 27},
    '{450, 0,  0}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_valid = 1'b0;
  logic [InW-1:0]  s_data = '0;
  logic            m_ready = 1'b0;
  logic            s_axis_tready;
  logic            m_axis_tvalid;
  logic [OutW-1:0] m_axis_tdata;

  dq_word_t dq_pending[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       samples_sent = 0;
  int       words_checked = 0;
  int       fail_count = 0;

  park_transform_rotator_core #(
    .DATA_WIDTH   (DataW),
    .ANGLE_WIDTH  (AngleW),
    .CORDIC_STAGES(Stages)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic signed [DataW-1:0] round_saturate(longint v);
    longint r;
    r = (v + (longint'(1) <<< (Guard - 1))) >>> Guard;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[DataW-1:0];
  endfunction

  function automatic dq_word_t rotate_to_rotor(logic [DataW-1:0] alpha,
                                               logic [DataW-1:0] beta,
                                               logic [AngleW-1:0] angle);
    dq_word_t   res;
    logic [31:0] theta, phi, sum, rest;
    logic [1:0]  quad;
    longint      x, y, z, t, dx, dy, gain;
    theta = {angle, {(32-AngleW){1'b0}}};
    phi   = 32'h0 - theta;
    sum   = phi + 32'h2000_0000;
    quad  = sum[31:30];
    rest  = phi - {quad, 30'h0};
    z     = longint'($signed(rest));
    gain  = longint'(InvGain);
    x = (longint'($signed(alpha)) * gain) >>> (32 - Guard);
    y = (longint'($signed(beta)) * gain) >>> (32 - Guard);
    case (quad)
      2'd1: begin
        t = x; x = -y; y = t;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTurn[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTurn[i]);
      end
    end
    res.d_cur = round_saturate(x);
    res.q_cur = round_saturate(y);
    return res;
  endfunction

  function automatic logic [DataW-1:0] pick_current();
    logic [DataW-1:0] v;
    case ($urandom_range(3))
      0: v = DataW'($urandom_range(64)) - DataW'(32);
      1: v = $urandom_range(1) ? 16'h7FFF - DataW'($urandom_range(15))
                               : 16'h8000 + DataW'($urandom_range(15));
      default: v = DataW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_sample(sample_row_t row);
    dq_word_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {row.angle, row.beta, row.alpha};
    do @(posedge clk_i); while (!s_axis_tready);
    want = rotate_to_rotor(row.alpha, row.beta, row.angle);
    if (row.fixed_d) want.d_cur = row.d_cur;
    if (row.fixed_q) want.q_cur = row.q_cur;
    dq_pending.push_back(want);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    s_valid = 1'b0;
    while (dq_pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    dq_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      got = m_axis_tdata[2*DataW-1:0];
      if (dq_pending.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxShown)
          $display("%0t: unexpected output word d=%0d q=%0d", $realtime,
                   got.d_cur, got.q_cur);
      end else begin
        want = dq_pending.pop_front();
        words_checked++;
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MaxShown)
            $display("%0t: mismatch d exp %0d got %0d, q exp %0d got %0d",
                     $realtime, want.d_cur, got.d_cur, want.q_cur, got.q_cur);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    sample_row_t row;
    int          wait_cycles;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NumRows; r++) send_sample(DirectedRows[r]);
    drain_pipeline();

    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = FlowPhases[p].send_idle;
      recv_stall_pct = FlowPhases[p].recv_stall;
      for (int n = 0; n < FlowPhases[p].count; n++) begin
        row = '0;
        row.alpha = pick_current();
        row.beta  = pick_current();
        case ($urandom_range(2))
          0: row.angle = {3'($urandom_range(7)), 13'h0} + AngleW'($urandom_range(4))
                         - AngleW'(2);
          default: row.angle = AngleW'($urandom);
        endcase
        send_sample(row);
      end
      drain_pipeline();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_cycles = 0;
    while (dq_pending.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * Latency) @(posedge clk_i);
    if (dq_pending.size() != 0) fail_count += dq_pending.size();

    $display("sent %0d samples (%0d directed) over %0d flow-control phases",
             samples_sent, NumRows, NumPhases);
    $display("checked %0d d/q words, %0d failures", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
